// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define CHK_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lbm_pkg.sv =====
package lbm_pkg;

  localparam int PANEL_W       = 16;
  localparam int PANEL_H       = 8;
  localparam int MAX_LEVEL     = 15;
  localparam int PANELS_ACROSS = 2;
  localparam int PANELS_DOWN   = 2;

  localparam int HALF_LEN  = PANEL_W * PANEL_H / 2;
  localparam int PLANE_LEN = PANELS_ACROSS * PANELS_DOWN * HALF_LEN;
  localparam int PLANE_SH  = $clog2(PLANE_LEN);

  localparam int COL_W   = $clog2(PANEL_W / 4);
  localparam int ROW_W   = $clog2(PANEL_H / 2);
  localparam int LEVEL_W = $clog2(MAX_LEVEL + 1);
  localparam int ADDR_W  = 12;
  localparam int CFG_W   = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [ADDR_W-1:0] ADDR_FLIP = ADDR_W'(2);
  localparam logic [LEVEL_W-1:0] LEVEL_LAST = LEVEL_W'(MAX_LEVEL);

  localparam logic [CFG_IDX_W-1:0] REG_MAP_X0_Y0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_X0_Y1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_X1_Y0 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_X1_Y1 = 2'd3;

  typedef struct packed {
    logic [4:0] pos_x;
    logic [3:0] pos_y;
    logic [7:0] top_red_one;
    logic [7:0] top_red_two;
    logic [7:0] top_green;
    logic [7:0] top_blue;
    logic [7:0] bot_red_one;
    logic [7:0] bot_red_two;
    logic [7:0] bot_green;
    logic [7:0] bot_blue;
  } pixel_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] buf_address;
    logic [7:0]        buf_byte;
    logic              last_level;
  } byte_out_t;

endpackage

// ===== rtl/led_matrix_bitplane_mapper_core.sv =====
// start-up: the accepting edge loads item_r and sets active_r, then out_r registers the first result with out_strobe
// throughput: MAX_LEVEL+1 results (16) per pixel pair, one per cycle, set by the level counter
// busy drops during the last level so the next pair follows with no gap
// bottom-half rows produce no result and leave the core idle
// reset: synchronous active-low rst_n clears control and restores the default panel map
module led_matrix_bitplane_mapper_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  lbm_pkg::pixel_in_t                  in_data,
  output logic                                out_strobe,
  output lbm_pkg::byte_out_t                  out_data,
  input  logic                                cfg_we,
  input  logic [lbm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lbm_pkg::CFG_W-1:0]           cfg_data
);
  import lbm_pkg::*;

  `include "assert_macros.svh"

  logic [CFG_W-1:0]   map_x0_y0_r, map_x0_y1_r, map_x1_y0_r, map_x1_y1_r;
  pixel_in_t          item_r;
  logic               active_r, active_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic               out_strobe_r;
  byte_out_t          out_r, out_nxt;
  logic               accept;
  logic               top_half;
  logic               last;
  logic [CFG_W-1:0]   slot;
  logic [7:0]         base;
  logic [7:0]         lvl8;
  logic [7:0]         bits;

  assign last     = (level_r == LEVEL_LAST);
  assign busy     = active_r && !last;
  assign accept   = start && !busy;
  assign top_half = !in_data.pos_y[ROW_W];

  always_comb begin
    case ({item_r.pos_x[4], item_r.pos_y[3]})
      2'b00:   slot = map_x0_y0_r;
      2'b01:   slot = map_x0_y1_r;
      2'b10:   slot = map_x1_y0_r;
      default: slot = map_x1_y1_r;
    endcase
    base = {slot, item_r.pos_x[3:COL_W], item_r.pos_y[ROW_W-1:0], item_r.pos_x[COL_W-1:0]};
    lvl8 = 8'(level_r);
    bits[0] = ((base & 8'(PLANE_LEN - 1)) == 8'(PLANE_LEN - 1));
    bits[1] = item_r.top_red_two > lvl8;
    bits[2] = item_r.top_green   > lvl8;
    bits[3] = item_r.top_blue    > lvl8;
    bits[4] = item_r.bot_red_one > lvl8;
    bits[5] = item_r.bot_red_two > lvl8;
    bits[6] = item_r.bot_green   > lvl8;
    bits[7] = item_r.bot_blue    > lvl8;
    out_nxt.buf_address = (ADDR_W'(base) + (ADDR_W'(level_r) << PLANE_SH)) ^ ADDR_FLIP;
    out_nxt.buf_byte    = bits;
    out_nxt.last_level  = last;
  end

  always_comb begin
    active_nxt = active_r;
    level_nxt  = level_r;
    if (active_r) begin
      level_nxt = level_r + LEVEL_W'(1);
      if (last) begin
        active_nxt = 1'b0;
      end
    end
    if (accept) begin
      active_nxt = top_half;
      level_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_x0_y0_r  <= 2'd0;
      map_x0_y1_r  <= 2'd1;
      map_x1_y0_r  <= 2'd2;
      map_x1_y1_r  <= 2'd3;
      active_r     <= 1'b0;
      level_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MAP_X0_Y0: map_x0_y0_r <= cfg_data;
          REG_MAP_X0_Y1: map_x0_y1_r <= cfg_data;
          REG_MAP_X1_Y0: map_x1_y0_r <= cfg_data;
          REG_MAP_X1_Y1: map_x1_y1_r <= cfg_data;
          default: ;
        endcase
      end
      active_r     <= active_nxt;
      level_r      <= level_nxt;
      out_strobe_r <= active_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    if (active_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

  `CHK_SAME(a_run_starts, accept && top_half, ##2 out_strobe, "accepted pair gave no result")
  `CHK_NEXT(a_run_contig, out_strobe && !out_data.last_level, out_strobe, "gap inside a run")
  `CHK_SAME(a_plane_end, out_strobe && out_data.buf_byte[0],
    out_data.buf_address[PLANE_SH-1:0] == PLANE_SH'(PLANE_LEN - 3),
    "plane end mark at wrong address")
  `CHK_SAME(a_busy_idle, !active_r, !busy, "busy without an active pair")

endmodule
